[rtl/xyr_pkg.sv]
// shared types, constants and the xy routing function for the router port service unit
package xyr_pkg;

    localparam int NPORTS     = 5;
    localparam int QDEPTH     = 8;
    localparam int COORD_W    = 4;
    localparam int PAYLOAD_W  = 32;
    localparam int CNT_W      = 32;
    localparam int PORT_W     = 3;
    localparam int QIDX_W     = $clog2(QDEPTH);
    localparam int FILL_W     = $clog2(QDEPTH + 1);
    localparam int MEM_DEPTH  = NPORTS * QDEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic OP_ARRIVE  = 1'b0;
    localparam logic OP_TICK    = 1'b1;
    localparam logic ST_ROUTED  = 1'b0;
    localparam logic ST_DROPPED = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE = 2'd2;

    typedef logic [COORD_W-1:0]   coord_t;
    typedef logic [PAYLOAD_W-1:0] body_t;
    typedef logic [PORT_W-1:0]    port_w_t;
    typedef logic [QIDX_W-1:0]    qidx_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [NPORTS-1:0]    pmask_t;

    typedef enum logic [PORT_W-1:0] {
        PORT_LOCAL  = 3'd0,
        PORT_LEFT   = 3'd1,
        PORT_RIGHT  = 3'd2,
        PORT_UPPER  = 3'd3,
        PORT_BOTTOM = 3'd4
    } port_t;

    typedef enum logic {
        CMD_DROP = 1'b0,
        CMD_TICK = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        coord_t dx;
        coord_t dy;
        body_t  body;
    } msg_t;

    typedef struct packed {
        cmd_kind_t                      kind;
        port_w_t                        port;
        msg_t                           msg;
        pmask_t                         mask;
        logic [NPORTS-1:0][QIDX_W-1:0]  heads;
    } cmd_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        msg_t  msg;
    } mem_wr_t;

    typedef struct packed {
        logic tick_done;
    } back_stat_t;

    function automatic addr_t mem_addr(port_w_t port, qidx_t idx);
        addr_t a;
        a = ADDR_W'(ADDR_W'(port) * ADDR_W'(QDEPTH) + ADDR_W'(idx));
        return a;
    endfunction

    function automatic port_w_t xy_route(port_w_t from, msg_t m, coord_t nx, coord_t ny,
                                         logic ring);
        port_w_t r;
        if (m.dx != nx) begin
            if (from == PORT_LEFT)
                r = PORT_RIGHT;
            else if (from == PORT_RIGHT)
                r = ring ? PORT_RIGHT : PORT_LEFT;
            else
                r = (m.dx > nx || ring) ? PORT_RIGHT : PORT_LEFT;
        end
        else if (m.dy == ny) begin
            r = PORT_LOCAL;
        end
        else if (from == PORT_UPPER) begin
            r = PORT_BOTTOM;
        end
        else if (from == PORT_BOTTOM) begin
            r = PORT_UPPER;
        end
        else begin
            r = (m.dy > ny) ? PORT_UPPER : PORT_BOTTOM;
        end
        return r;
    endfunction

endpackage

[rtl/xy_router_port_service_unit.sv]
// XY router port service unit: an arrive word on ports 0 to 4 is either queued (no
// result) or turned into a single drop result when its port queue already holds eight
// messages, and one on any other port is ignored. A tick word serving n non-empty queues
// gives n results, one per cycle while out_ready is high, after the command queue, the
// tick mask load, the message memory read and the output register, with the last flag
// on the final one; the single read port of the message memory sets that pace, and no
// new word is taken until the last read of the tick is issued. Results may be held off
// by out_ready without losing any. The memory needs no clearing after reset;
// configuration writes are taken every cycle.
module xy_router_port_service_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [xyr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xyr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [2:0]                    in_port,
    input  xyr_pkg::coord_t               dest_x,
    input  xyr_pkg::coord_t               dest_y,
    input  xyr_pkg::body_t                payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [2:0]                    out_port,
    output logic [2:0]                    from_port,
    output xyr_pkg::coord_t               msg_dest_x,
    output xyr_pkg::coord_t               msg_dest_y,
    output xyr_pkg::body_t                msg_payload,
    output logic [31:0]                   total_routed,
    output logic                          last
);
    import xyr_pkg::*;

    coord_t      node_x_reg;
    coord_t      node_y_reg;
    logic        ring_mode_reg;

    logic        cmd_push;
    cmd_t        push_cmd;
    logic        cmd_full;
    logic        cmd_pop;
    logic        cmd_valid;
    cmd_t        head_cmd;
    mem_wr_t     wr;
    back_stat_t  bstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_x_reg    <= '0;
            node_y_reg    <= '0;
            ring_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_X:    node_x_reg    <= cfg_data;
                CFG_NODE_Y:    node_y_reg    <= cfg_data;
                CFG_RING_MODE: ring_mode_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    xyr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .in_port   (in_port),
        .dest_x    (dest_x),
        .dest_y    (dest_y),
        .payload   (payload),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd),
        .cmd_full  (cmd_full),
        .wr        (wr),
        .bstat     (bstat)
    );

    xyr_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .valid    (cmd_valid),
        .head_cmd (head_cmd)
    );

    xyr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .wr           (wr),
        .bstat        (bstat),
        .node_x       (node_x_reg),
        .node_y       (node_y_reg),
        .ring_mode    (ring_mode_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_port     (out_port),
        .from_port    (from_port),
        .msg_dest_x   (msg_dest_x),
        .msg_dest_y   (msg_dest_y),
        .msg_payload  (msg_payload),
        .total_routed (total_routed),
        .last         (last)
    );

endmodule

[rtl/xyr_front.sv]
// front end: takes input words, keeps queue pointers and fills, issues drop and tick commands
module xyr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [2:0]           in_port,
    input  xyr_pkg::coord_t      dest_x,
    input  xyr_pkg::coord_t      dest_y,
    input  xyr_pkg::body_t       payload,
    output logic                 cmd_push,
    output xyr_pkg::cmd_t        cmd,
    input  logic                 cmd_full,
    output xyr_pkg::mem_wr_t     wr,
    input  xyr_pkg::back_stat_t  bstat
);
    import xyr_pkg::*;

    qidx_t               heads_reg [NPORTS];
    qidx_t               heads_next [NPORTS];
    logic [FILL_W-1:0]   fills_reg [NPORTS];
    logic [FILL_W-1:0]   fills_next [NPORTS];
    logic                tick_pend_reg;
    logic                tick_pend_next;
    logic                accept;
    logic                port_ok;
    pmask_t              live_mask;
    logic [QIDX_W:0]     tail_sum;
    qidx_t               tail;
    logic                fill_ovf;
    msg_t                in_msg;

    assign in_ready = !tick_pend_reg && !cmd_full;
    assign accept   = in_valid && in_ready;
    assign port_ok  = (in_port < PORT_W'(NPORTS));
    assign in_msg   = '{dx: dest_x, dy: dest_y, body: payload};

    always_comb
    begin
        for (int i = 0; i < NPORTS; i++)
        begin
            live_mask[i] = (fills_reg[i] != '0);
        end
    end

    // tail index wraps at the queue depth
    always_comb
    begin
        tail_sum = '0;
        if (port_ok)
        begin
            tail_sum = (QIDX_W+1)'(heads_reg[in_port]) + (QIDX_W+1)'(fills_reg[in_port]);
        end
        if (tail_sum >= (QIDX_W+1)'(QDEPTH))
            tail = QIDX_W'(tail_sum - (QIDX_W+1)'(QDEPTH));
        else
            tail = QIDX_W'(tail_sum);
    end

    always_comb
    begin
        heads_next     = heads_reg;
        fills_next     = fills_reg;
        tick_pend_next = tick_pend_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        wr             = '0;

        if (bstat.tick_done)
            tick_pend_next = 1'b0;

        if (accept)
        begin
            if (operation == OP_ARRIVE)
            begin
                if (port_ok)
                begin
                    if (fills_reg[in_port] == FILL_W'(QDEPTH))
                    begin
                        cmd_push  = 1'b1;
                        cmd.kind  = CMD_DROP;
                        cmd.port  = in_port;
                        cmd.msg   = in_msg;
                    end
                    else
                    begin
                        wr.en   = 1'b1;
                        wr.addr = mem_addr(in_port, tail);
                        wr.msg  = in_msg;
                        fills_next[in_port] = fills_reg[in_port] + 1'b1;
                    end
                end
            end
            else if (live_mask != '0)
            begin
                // pop every live queue now, the back end reads the slots in port order
                cmd_push       = 1'b1;
                cmd.kind       = CMD_TICK;
                cmd.mask       = live_mask;
                tick_pend_next = 1'b1;
                for (int i = 0; i < NPORTS; i++)
                begin
                    cmd.heads[i] = heads_reg[i];
                    if (live_mask[i])
                    begin
                        fills_next[i] = fills_reg[i] - 1'b1;
                        heads_next[i] = (heads_reg[i] == QIDX_W'(QDEPTH - 1)) ?
                                        '0 : heads_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPORTS; i++)
            begin
                heads_reg[i] <= '0;
                fills_reg[i] <= '0;
            end
            tick_pend_reg <= 1'b0;
        end
        else
        begin
            heads_reg     <= heads_next;
            fills_reg     <= fills_next;
            tick_pend_reg <= tick_pend_next;
        end
    end

    always_comb
    begin
        fill_ovf = 1'b0;
        for (int i = 0; i < NPORTS; i++)
        begin
            if (fills_reg[i] > FILL_W'(QDEPTH))
                fill_ovf = 1'b1;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) !fill_ovf)
        else $error("queue fill above depth");

    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        tick_pend_reg |-> !in_ready)
        else $error("input taken while tick reads pending");

    a_tick_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd.kind == CMD_TICK) |=> tick_pend_reg)
        else $error("tick command without pending mark");

endmodule

[rtl/xyr_cmdq.sv]
// short command queue between front and back end
module xyr_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  xyr_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output xyr_pkg::cmd_t  head_cmd
);
    import xyr_pkg::*;

    cmd_t                    entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0]   count_reg;
    logic [CMDQ_CNT_W-1:0]   count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/xyr_back.sv]
// back end: message memory, tick read sequencing, routing and output register
module xyr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  xyr_pkg::cmd_t        cmd,
    output logic                 cmd_pop,
    input  xyr_pkg::mem_wr_t     wr,
    output xyr_pkg::back_stat_t  bstat,
    input  xyr_pkg::coord_t      node_x,
    input  xyr_pkg::coord_t      node_y,
    input  logic                 ring_mode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 status,
    output logic [2:0]           out_port,
    output logic [2:0]           from_port,
    output xyr_pkg::coord_t      msg_dest_x,
    output xyr_pkg::coord_t      msg_dest_y,
    output xyr_pkg::body_t       msg_payload,
    output logic [31:0]          total_routed,
    output logic                 last
);
    import xyr_pkg::*;

    msg_t                           mem [MEM_DEPTH];

    pmask_t                         tick_mask_reg;
    logic [NPORTS-1:0][QIDX_W-1:0]  tick_heads_reg;

    logic                           s1_valid_reg;
    logic                           s1_drop_reg;
    port_w_t                        s1_port_reg;
    logic                           s1_last_reg;
    msg_t                           s1_drop_msg_reg;
    msg_t                           mem_q_reg;

    logic                           out_valid_reg;
    logic                           out_status_reg;
    port_w_t                        out_port_reg;
    port_w_t                        out_from_reg;
    msg_t                           out_msg_reg;
    logic [CNT_W-1:0]               out_total_reg;
    logic                           out_last_reg;
    logic [CNT_W-1:0]               routed_count_reg;
    logic [CNT_W-1:0]               routed_count_next;

    logic                           tick_active;
    logic                           adv_out;
    logic                           s1_ok;
    logic                           s1_take;
    logic                           issue;
    logic                           drop_pop;
    logic                           tick_pop;
    port_w_t                        cur_idx;
    pmask_t                         rem_mask;
    addr_t                          rd_addr;
    msg_t                           s1_msg;

    assign tick_active = (tick_mask_reg != '0);
    assign adv_out     = !out_valid_reg || out_ready;
    assign s1_take     = s1_valid_reg && adv_out;
    assign s1_ok       = !s1_valid_reg || adv_out;
    assign issue       = tick_active && s1_ok;
    assign drop_pop    = cmd_valid && !tick_active && (cmd.kind == CMD_DROP) && s1_ok;
    assign tick_pop    = cmd_valid && !tick_active && (cmd.kind == CMD_TICK);
    assign cmd_pop     = drop_pop || tick_pop;

    // lowest live port goes first
    always_comb
    begin
        cur_idx = '0;
        for (int i = NPORTS - 1; i >= 0; i--)
        begin
            if (tick_mask_reg[i])
                cur_idx = PORT_W'(i);
        end
    end

    assign rem_mask        = tick_mask_reg & (tick_mask_reg - 1'b1);
    assign rd_addr         = mem_addr(cur_idx, tick_heads_reg[cur_idx]);
    assign bstat.tick_done = issue && (rem_mask == '0);
    assign s1_msg          = s1_drop_reg ? s1_drop_msg_reg : mem_q_reg;

    assign routed_count_next = routed_count_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.msg;
        if (issue)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (drop_pop)
            s1_drop_msg_reg <= cmd.msg;
        if (tick_pop)
            tick_heads_reg <= cmd.heads;
        if (s1_take)
        begin
            out_msg_reg  <= s1_msg;
            out_from_reg <= s1_port_reg;
            out_last_reg <= s1_drop_reg ? 1'b1 : s1_last_reg;
            if (s1_drop_reg)
            begin
                out_status_reg <= ST_DROPPED;
                out_port_reg   <= PORT_LOCAL;
                out_total_reg  <= routed_count_reg;
            end
            else
            begin
                out_status_reg <= ST_ROUTED;
                out_port_reg   <= xy_route(s1_port_reg, s1_msg, node_x, node_y, ring_mode);
                out_total_reg  <= routed_count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_mask_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s1_drop_reg      <= 1'b0;
            s1_port_reg      <= '0;
            s1_last_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            routed_count_reg <= '0;
        end
        else
        begin
            if (tick_pop)
                tick_mask_reg <= cmd.mask;
            else if (issue)
                tick_mask_reg <= rem_mask;

            if (issue)
            begin
                s1_valid_reg <= 1'b1;
                s1_drop_reg  <= 1'b0;
                s1_port_reg  <= cur_idx;
                s1_last_reg  <= (rem_mask == '0);
            end
            else if (drop_pop)
            begin
                s1_valid_reg <= 1'b1;
                s1_drop_reg  <= 1'b1;
                s1_port_reg  <= cmd.port;
                s1_last_reg  <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (s1_take && !s1_drop_reg)
                routed_count_reg <= routed_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_port     = out_port_reg;
    assign from_port    = out_from_reg;
    assign msg_dest_x   = out_msg_reg.dx;
    assign msg_dest_y   = out_msg_reg.dy;
    assign msg_payload  = out_msg_reg.body;
    assign total_routed = out_total_reg;
    assign last         = out_last_reg;

    a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        tick_active |=> ((tick_mask_reg & ~$past(tick_mask_reg)) == '0))
        else $error("tick mask gained a port mid-tick");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(routed_count_reg))
        else $error("routed count moved while output stalled");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(issue && cmd_pop))
        else $error("command popped during tick read");

endmodule

[test/xy_router_port_service_unit_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the xy router port service unit: queueing, drops and xy routing
module xy_router_port_service_unit_test;
    import xyr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int FLOOD_WORDS   = QDEPTH + 1;

    typedef struct packed {
        logic        status;
        port_w_t     out_port;
        port_w_t     from_port;
        coord_t      dx;
        coord_t      dy;
        body_t       body;
        logic [31:0] total;
        logic        last;
    } route_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  operation = OP_ARRIVE;
    logic [2:0]            in_port = '0;
    coord_t                dest_x = '0;
    coord_t                dest_y = '0;
    body_t                 payload = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  status;
    logic [2:0]            out_port;
    logic [2:0]            from_port;
    coord_t                msg_dest_x;
    coord_t                msg_dest_y;
    body_t                 msg_payload;
    logic [31:0]           total_routed;
    logic                  last;

    // predictor state
    coord_t        cur_node_x = '0;
    coord_t        cur_node_y = '0;
    logic          cur_ring = 1'b0;
    msg_t          slot_mem[NPORTS][QDEPTH];
    int            slot_head[NPORTS];
    int            slot_fill[NPORTS];
    logic [31:0]   routed_total = '0;
    route_result_t expected_routes[$];

    int            err_count = 0;
    bit            idle_on = 1'b1;
    int            out_stall = 0;

    xy_router_port_service_unit u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stalls at random in bursts, started only while idle_on is set
    always @(posedge clk)
    begin
        if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= $urandom_range(1, 4) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        route_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_routes.size() == 0)
            begin
                $error("unexpected result word: from_port %0d payload %0h", from_port,
                       msg_payload);
                err_count++;
            end
            else
            begin
                want = expected_routes.pop_front();
                check_field("status", want.status, status);
                check_field("out_port", want.out_port, out_port);
                check_field("from_port", want.from_port, from_port);
                check_field("msg_dest_x", want.dx, msg_dest_x);
                check_field("msg_dest_y", want.dy, msg_dest_y);
                check_field("msg_payload", want.body, msg_payload);
                check_field("total_routed", want.total, total_routed);
                check_field("last", want.last, last);
            end
        end
    end

    function automatic port_w_t predict_out_port(port_w_t src, msg_t m);
        port_w_t dir;
        if (m.dx != cur_node_x)
        begin
            case (src)
                PORT_LEFT:  dir = PORT_RIGHT;
                PORT_RIGHT: dir = cur_ring ? PORT_RIGHT : PORT_LEFT;
                default:    dir = (cur_ring || m.dx > cur_node_x) ? PORT_RIGHT : PORT_LEFT;
            endcase
        end
        else if (m.dy == cur_node_y)
        begin
            dir = PORT_LOCAL;
        end
        else
        begin
            // vertical traffic keeps going the way it came
            case (src)
                PORT_UPPER:  dir = PORT_BOTTOM;
                PORT_BOTTOM: dir = PORT_UPPER;
                default:     dir = (m.dy > cur_node_y) ? PORT_UPPER : PORT_BOTTOM;
            endcase
        end
        return dir;
    endfunction

    task automatic predict_routes(input logic op, input logic [2:0] port, input coord_t dx,
                                  input coord_t dy, input body_t body);
        msg_t          m;
        route_result_t r;
        int            busy_ports;
        int            tail;
        m.dx   = dx;
        m.dy   = dy;
        m.body = body;
        if (op == OP_ARRIVE)
        begin
            if (port < NPORTS)
            begin
                if (slot_fill[port] >= QDEPTH)
                begin
                    r.status    = ST_DROPPED;
                    r.out_port  = PORT_LOCAL;
                    r.from_port = port;
                    r.dx        = dx;
                    r.dy        = dy;
                    r.body      = body;
                    r.total     = routed_total;
                    r.last      = 1'b1;
                    expected_routes.push_back(r);
                end
                else
                begin
                    tail = (slot_head[port] + slot_fill[port]) % QDEPTH;
                    slot_mem[port][tail] = m;
                    slot_fill[port]++;
                end
            end
        end
        else
        begin
            busy_ports = 0;
            for (int p = 0; p < NPORTS; p++)
                if (slot_fill[p] != 0)
                    busy_ports++;
            for (int p = 0; p < NPORTS; p++)
            begin
                if (slot_fill[p] != 0)
                begin
                    m = slot_mem[p][slot_head[p]];
                    slot_head[p] = (slot_head[p] + 1) % QDEPTH;
                    slot_fill[p]--;
                    routed_total = routed_total + 1;
                    busy_ports--;
                    r.status    = ST_ROUTED;
                    r.out_port  = predict_out_port(port_w_t'(p), m);
                    r.from_port = port_w_t'(p);
                    r.dx        = m.dx;
                    r.dy        = m.dy;
                    r.body      = m.body;
                    r.total     = routed_total;
                    r.last      = (busy_ports == 0);
                    expected_routes.push_back(r);
                end
            end
        end
    endtask

    // valid stays high between back-to-back words, dropped only for an idle burst
    task automatic send_word(input logic op, input logic [2:0] port, input coord_t dx,
                             input coord_t dy, input body_t body);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        in_port   <= port;
        dest_x    <= dx;
        dest_y    <= dy;
        payload   <= body;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_routes(op, port, dx, dy, body);
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_config(input coord_t nx, input coord_t ny, input logic ring);
        logic [CFG_IDX_W-1:0]  idx[3];
        logic [CFG_DATA_W-1:0] val[3];
        idx[0] = CFG_NODE_X;
        val[0] = nx;
        idx[1] = CFG_NODE_Y;
        val[1] = ny;
        idx[2] = CFG_RING_MODE;
        val[2] = CFG_DATA_W'(ring);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CFG_NODE_X:    cur_node_x = val[i];
                CFG_NODE_Y:    cur_node_y = val[i];
                CFG_RING_MODE: cur_ring = val[i][0];
                default:       ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly arrivals, often aimed at this node, with ticks, floods and out-of-range ports
    task automatic send_random_words(input int count);
        int         sent;
        int         pick;
        logic [2:0] port;
        coord_t     dx;
        coord_t     dy;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            dx = ($urandom_range(0, 2) == 0) ? cur_node_x : coord_t'($urandom);
            dy = ($urandom_range(0, 2) == 0) ? cur_node_y : coord_t'($urandom);
            if (pick < 28)
            begin
                send_word(OP_TICK, 3'($urandom), coord_t'($urandom), coord_t'($urandom),
                          $urandom);
                sent++;
            end
            else if (pick < 33)
            begin
                // ignored by the block, not counted
                send_word(OP_ARRIVE, 3'($urandom_range(NPORTS, 7)), dx, dy, $urandom);
            end
            else if (pick < 36)
            begin
                port = 3'($urandom_range(0, NPORTS - 1));
                repeat (FLOOD_WORDS)
                    send_word(OP_ARRIVE, port, coord_t'($urandom), coord_t'($urandom),
                              $urandom);
                sent += FLOOD_WORDS;
            end
            else
            begin
                send_word(OP_ARRIVE, 3'($urandom_range(0, NPORTS - 1)), dx, dy, $urandom);
                sent++;
            end
        end
    endtask

    task automatic run_random_phase(input coord_t nx, input coord_t ny, input logic ring,
                                    input int count);
        wait_until_idle();
        write_node_config(nx, ny, ring);
        send_random_words(count);
    endtask

    // reset configuration: empty ticks and arrivals on ports that do not exist
    task automatic test_empty_and_ignored();
        send_word(OP_TICK, 3'd7, 4'hf, 4'hf, 32'hffff_ffff);
        send_word(OP_ARRIVE, 3'(NPORTS), 4'h3, 4'h5, 32'h1234_5678);
        send_word(OP_ARRIVE, 3'd7, 4'hf, 4'h0, 32'hffff_ffff);
        send_word(OP_TICK, 3'd0, 4'h0, 4'h0, 32'h0);
    endtask

    // fill one queue past its depth with extreme field values
    task automatic test_queue_overflow();
        body_t body;
        wait_until_idle();
        write_node_config(4'h0, 4'h0, 1'b0);
        for (int i = 0; i < FLOOD_WORDS; i++)
        begin
            case (i % 4)
                0:       body = 32'h0000_0000;
                1:       body = 32'hffff_ffff;
                2:       body = 32'h5555_5555;
                default: body = 32'haaaa_aaaa;
            endcase
            send_word(OP_ARRIVE, PORT_BOTTOM, i[0] ? 4'hf : 4'h0, i[0] ? 4'h0 : 4'hf, body);
        end
        send_word(OP_TICK, PORT_LOCAL, 4'h0, 4'h0, 32'h0);
    endtask

    // two rounds of one message per port across the direction cases, each served by a tick
    task automatic test_directed_routing();
        wait_until_idle();
        write_node_config(4'h8, 4'h8, 1'b0);
        send_word(OP_ARRIVE, PORT_LOCAL, 4'hc, 4'h8, 32'h0000_0001);
        send_word(OP_ARRIVE, PORT_LEFT, 4'h3, 4'h8, 32'h0000_0002);
        send_word(OP_ARRIVE, PORT_RIGHT, 4'h8, 4'h2, 32'h0000_0003);
        send_word(OP_ARRIVE, PORT_UPPER, 4'h8, 4'hc, 32'h0000_0004);
        send_word(OP_ARRIVE, PORT_BOTTOM, 4'h8, 4'h8, 32'h0000_0005);
        send_word(OP_TICK, PORT_LOCAL, 4'h0, 4'h0, 32'h0);
        // local message for this very node goes to local delivery
        send_word(OP_ARRIVE, PORT_LOCAL, 4'h8, 4'h8, 32'h0000_0006);
        send_word(OP_ARRIVE, PORT_LEFT, 4'h8, 4'hc, 32'h0000_0007);
        send_word(OP_ARRIVE, PORT_RIGHT, 4'h1, 4'h8, 32'h0000_0008);
        send_word(OP_ARRIVE, PORT_UPPER, 4'h2, 4'h3, 32'h0000_0009);
        send_word(OP_ARRIVE, PORT_BOTTOM, 4'h8, 4'h1, 32'h0000_000a);
        send_word(OP_TICK, PORT_LOCAL, 4'h0, 4'h0, 32'h0);
    endtask

    task automatic test_random_mesh();
        run_random_phase(4'hf, 4'hf, 1'b0, 45);
        run_random_phase(coord_t'($urandom), coord_t'($urandom), 1'b0, 40);
    endtask

    task automatic test_random_ring();
        run_random_phase(4'hf, 4'h0, 1'b1, 40);
        run_random_phase(coord_t'($urandom), coord_t'($urandom), 1'b1, 35);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic test_pause_until_empty();
        run_random_phase(4'h5, 4'ha, 1'b0, 20);
        wait_until_idle();
        send_random_words(20);
    endtask

    task automatic test_back_to_back();
        wait_until_idle();
        idle_on = 1'b0;
        write_node_config(coord_t'($urandom), coord_t'($urandom), 1'b0);
        send_random_words(40);
    endtask

    initial
    begin
        for (int p = 0; p < NPORTS; p++)
        begin
            slot_head[p] = 0;
            slot_fill[p] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_and_ignored();
        test_queue_overflow();
        test_directed_routing();
        test_random_mesh();
        test_random_ring();
        test_pause_until_empty();
        test_back_to_back();
        wait_until_idle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
